// File: sv/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // value returned by a get that misses
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  // value returned by every put
  localparam logic [VAL_W-1:0] PUT_VALUE = 32'h0000_0000;

endpackage

`default_nettype wire

// File: sv/lru_key_value_cache.sv
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// Requests: start with in_opcode (get/put), in_key, in_value. A request is
// taken at a clock edge where start is high and busy is low.
// Results: out_strobe marks one cycle holding out_hit and out_read_value.
// A get returns the stored value on a hit and all ones on a miss; a put
// returns zero, with out_hit telling whether the key was already present.
// Configuration: cfg_we/cfg_wdata write capacity_in_use (0 acts as 1, values
// above MAX_ENTRIES saturate). Write it only while no request is in flight.
// Timing: a taken request is held in the request register, evaluated, and its
// result is registered in the result register that drives the beat. One request per
// cycle is sustained: the input register feeds a single stage of parallel
// key compares, rank updates and slot selection, whose state writes land
// before the next request is evaluated.
// Reset (rst_n low, synchronous) empties the cache, restores capacity 16 and
// drops any request in flight; busy is high only during reset and the cycle
// right after it. The receiver takes every beat and cannot stall the block.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire                     in_opcode,
  input  wire  signed [KEY_W-1:0] in_key,
  input  wire  signed [VAL_W-1:0] in_value,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic signed [VAL_W-1:0] out_read_value,
  input  wire                     cfg_we,
  input  wire         [CAP_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // control
  logic             busy_r;
  logic             req_vld_r;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] occ_r, occ_nxt;

  // request register
  logic             req_op_r;
  logic [KEY_W-1:0] req_key_r;
  logic [VAL_W-1:0] req_val_r;

  // entry storage
  logic [KEY_W-1:0]   key_r   [MAX_ENTRIES];
  logic [VAL_W-1:0]   val_r   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]   rank_r  [MAX_ENTRIES];
  logic [IDX_W-1:0]   rank_nxt[MAX_ENTRIES];

  // result register
  logic             res_vld_r;
  logic             res_hit_r;
  logic [VAL_W-1:0] res_val_r;

  // lookup and replacement decode
  logic [MAX_ENTRIES-1:0] match_vec;
  logic             found;
  logic [IDX_W-1:0] hit_idx, free_idx, victim_idx, slot;
  logic [CNT_W-1:0] occ_m1, old_rank;
  logic [CMP_W-1:0] eff_cap;
  logic             full;
  logic             is_put, do_update, do_insert, write_kv;

  assign busy = busy_r;

  always_comb begin
    occ_m1 = occ_r - CNT_W'(1);
    match_vec = '0;
    hit_idx = '0;
    free_idx = '0;
    victim_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (key_r[i] == req_key_r);
    end
    // lowest-numbered match and free slot win
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
      // valid ranks are always 0..occ-1, so the oldest holds occ-1
      if (valid_r[i] && (CNT_W'(rank_r[i]) == occ_m1)) begin
        victim_idx = IDX_W'(i);
      end
    end
    found = |match_vec;

    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_r);
    end
    full = CMP_W'(occ_r) >= eff_cap;

    is_put    = req_op_r == OP_PUT;
    do_update = req_vld_r && (found || is_put);
    write_kv  = req_vld_r && is_put;
    do_insert = write_kv && !found && !full;

    if (found) begin
      slot     = hit_idx;
      old_rank = CNT_W'(rank_r[hit_idx]);
    end else if (full) begin
      slot     = victim_idx;
      old_rank = occ_m1;
    end else begin
      slot     = free_idx;
      old_rank = occ_r;
    end

    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_update) begin
        if (IDX_W'(i) == slot) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (CNT_W'(rank_r[i]) < old_rank)) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
    end
    if (do_insert) begin
      valid_nxt[slot] = 1'b1;
      occ_nxt         = occ_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      cap_r     <= CAP_RESET;
      occ_r     <= '0;
      valid_r   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      busy_r    <= 1'b0;
      req_vld_r <= start && !busy_r;
      res_vld_r <= req_vld_r;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      occ_r   <= occ_nxt;
      valid_r <= valid_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      req_op_r  <= in_opcode;
      req_key_r <= in_key;
      req_val_r <= in_value;
    end
    if (write_kv) begin
      key_r[slot] <= req_key_r;
      val_r[slot] <= req_val_r;
    end
    res_hit_r <= found;
    if (is_put) begin
      res_val_r <= PUT_VALUE;
    end else if (found) begin
      res_val_r <= val_r[hit_idx];
    end else begin
      res_val_r <= MISS_VALUE;
    end
  end

  assign out_strobe     = res_vld_r;
  assign out_hit        = res_hit_r;
  assign out_read_value = res_val_r;

endmodule

`default_nettype wire

// File: sv/lkvc_chk.sv
`default_nettype none

module lkvc_chk
  import lkvc_pkg::*;
(
  input wire                     clk,
  input wire                     rst_n,
  input wire                     start,
  input wire                     busy,
  input wire                     in_opcode,
  input wire  signed [KEY_W-1:0] in_key,
  input wire                     out_strobe,
  input wire                     out_hit,
  input wire  signed [VAL_W-1:0] out_read_value
);

  logic acc;
  assign acc = start && !busy;

  // every accepted request yields exactly one result beat
  a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ##1 out_strobe)
    else $error("accepted request produced no result beat");

  a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc, 2))
    else $error("result beat without a request");

  a_put_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ($past(in_opcode, 2) == OP_PUT) |-> out_read_value == PUT_VALUE)
    else $error("put returned a nonzero value");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ($past(in_opcode, 2) == OP_GET) && !out_hit
      |-> out_read_value == MISS_VALUE)
    else $error("get miss did not return all ones");

  // a get straight after a put of the same key must hit
  a_put_then_get: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_opcode == OP_PUT)) ##1
      (acc && (in_opcode == OP_GET) && (in_key == $past(in_key)))
      |=> ##1 (out_strobe && out_hit))
    else $error("get after put of same key missed");

endmodule

bind lru_key_value_cache lkvc_chk u_lkvc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_opcode      (in_opcode),
  .in_key         (in_key),
  .out_strobe     (out_strobe),
  .out_hit        (out_hit),
  .out_read_value (out_read_value)
);

`default_nettype wire

// File: sim/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
  import lkvc_pkg::*;

  localparam int SLOTS = 16;
  localparam int LATENCY = 2;
  localparam int POOL_MAX = 24;

  // Tracks cache contents and recency ranks; holds the replies still due.
  class lru_scoreboard;
    typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] value;
    } reply_t;

    logic [KEY_W-1:0] slot_key [SLOTS];
    logic [VAL_W-1:0] slot_value [SLOTS];
    bit               slot_valid [SLOTS];
    int               slot_rank [SLOTS];
    int               occupancy;
    logic [CAP_W-1:0] capacity;
    reply_t           expected_replies [$];
    int               errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i] = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_rank[i] = 0;
      end
      occupancy = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int cap_limit();
      int c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
    endfunction

    // Age every valid entry more recent than old_rank; slot s becomes newest.
    function void make_newest(int s, int old_rank);
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
      slot_rank[s] = 0;
    endfunction

    function void note_request(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int     s;
      int     oldest;
      bit     found;
      reply_t r;
      s = 0;
      found = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && slot_valid[i] && slot_key[i] == k) begin
          s = i;
          found = 1;
        end
      end
      r.hit = found;
      r.value = PUT_VALUE;
      if (op == OP_GET) begin
        if (found) begin
          r.value = slot_value[s];
          make_newest(s, slot_rank[s]);
        end else begin
          r.value = MISS_VALUE;
        end
      end else if (found) begin
        slot_value[s] = v;
        make_newest(s, slot_rank[s]);
      end else if (occupancy >= cap_limit()) begin
        // evict the oldest valid entry, first one on a tie
        oldest = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && slot_rank[i] > oldest) begin
            oldest = slot_rank[i];
            s = i;
          end
        end
        slot_key[s] = k;
        slot_value[s] = v;
        make_newest(s, oldest);
      end else begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!slot_valid[i]) s = i;
        slot_valid[s] = 1'b1;
        slot_key[s] = k;
        slot_value[s] = v;
        make_newest(s, occupancy);
        occupancy++;
      end
      expected_replies = {expected_replies, r};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic hit, logic [VAL_W-1:0] value);
      reply_t r;
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected beat hit=%0b value=%h", hit, value));
      end else begin
        r = expected_replies.pop_front();
        if (hit !== r.hit)
          report($sformatf("hit %b, want %b", hit, r.hit));
        if (value !== r.value)
          report($sformatf("read_value %h, want %h", value, r.value));
      end
    endtask

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_opcode;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;
  logic             out_strobe;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lru_scoreboard    sb;
  int               sender_idle_pct;
  logic [KEY_W-1:0] key_pool [POOL_MAX];

  lru_key_value_cache uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_capacity(cfg_wdata);
      if (start && !busy) sb.note_request(in_opcode, in_key, in_value);
      if (out_strobe) sb.check_result(out_hit, out_read_value);
    end
  end

  task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      in_opcode <= 1'($urandom_range(1));
      in_key <= $urandom;
      @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_key <= k;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every reply is in, then let the pipeline empty.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(input logic [CAP_W-1:0] cap, input int idle_pct, input int count);
    int pool_size;
    int c;
    logic [KEY_W-1:0] k;
    drain();
    write_capacity(cap);
    sender_idle_pct = idle_pct;
    c = (cap == 0) ? 1 : (cap > SLOTS ? SLOTS : cap);
    pool_size = c + 3;
    // keep about half of the old keys so earlier contents still get hits
    for (int i = 0; i < POOL_MAX; i++)
      if ($urandom_range(1)) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(pool_size - 1)];
      send_request($urandom_range(1) ? OP_PUT : OP_GET, k, $urandom);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [8];
    int idles [8];
    caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd16};
    idles = '{0, 82, 31, 0, 82, 31, 0, 82};
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_GET;
    in_key = '0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sender_idle_pct = 0;
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // two entries: fill, hit, evict the oldest, overwrite, extreme keys and values
    write_capacity(5'd2);
    send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0005);
    send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);

    for (int p = 0; p < 8; p++) run_traffic(caps[p], idles[p], 240);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
